@@ rtl/core/joint_trajectory_interpolator_assert.svh @@
// Assertion macros shared by the interpolator RTL.
// Depends on clk_i and rst_ni being visible in the module that expands them.
`ifndef JOINT_TRAJECTORY_INTERPOLATOR_ASSERT_SVH
`define JOINT_TRAJECTORY_INTERPOLATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JTI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/jti_pkg.sv @@
// Package for the joint trajectory interpolator: field widths, codes and payload types.
// Used by the top level and jti_div; depends on nothing.
package jti_pkg;

  localparam int unsigned MAX_POINTS_DEF  = 64;
  localparam int unsigned JOINT_COUNT_DEF = 7;
  localparam int unsigned PORT_JOINTS     = 7;

  localparam int unsigned POS_W    = 20;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PERIOD_W = 20;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  // Magnitude of a step never exceeds the joint delta, so 21 quotient bits suffice.
  localparam int unsigned MAG_W    = POS_W + 1;
  localparam int unsigned DIV_BITS = MAG_W;
  localparam int unsigned PROD_W   = MAG_W + PERIOD_W;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [1:0] STAT_STARTED  = 2'd0;
  localparam logic [1:0] STAT_MOVING   = 2'd1;
  localparam logic [1:0] STAT_FINISHED = 2'd2;
  localparam logic [1:0] STAT_ABORTED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd1;

  typedef struct packed {
    logic [1:0]              kind;
    logic [IDX_W-1:0]        point_index;
    logic [TIME_W-1:0]       point_time_us;
    logic signed [POS_W-1:0] joint_0;
    logic signed [POS_W-1:0] joint_1;
    logic signed [POS_W-1:0] joint_2;
    logic signed [POS_W-1:0] joint_3;
    logic signed [POS_W-1:0] joint_4;
    logic signed [POS_W-1:0] joint_5;
    logic signed [POS_W-1:0] joint_6;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] cmd_joint_0;
    logic signed [POS_W-1:0] cmd_joint_1;
    logic signed [POS_W-1:0] cmd_joint_2;
    logic signed [POS_W-1:0] cmd_joint_3;
    logic signed [POS_W-1:0] cmd_joint_4;
    logic signed [POS_W-1:0] cmd_joint_5;
    logic signed [POS_W-1:0] cmd_joint_6;
    logic [1:0]              status;
    logic [IDX_W-1:0]        segment;
  } out_t;

  typedef struct packed {
    logic                  start;
    logic [MAG_W-1:0]      mag;
    logic [PERIOD_W-1:0]   period;
    logic [TIME_W-1:0]     dt;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ rtl/core/joint_trajectory_interpolator.sv @@
// Top level of the linear joint trajectory interpolator: sequencer, point tables
// in two RAMs, command registers and output register. Uses jti_pkg, jti_ram, jti_div.
//
//  channel | handshake               | payload
//  in      | in_valid_i / in_stall_o | in_data_i   (jti_pkg::in_t)
//  out     | out_valid_o/ out_stall_i| out_data_o  (jti_pkg::out_t)
//  cfg     | cfg_valid_i/ cfg_ready_o| cfg_index_i, cfg_data_i
//
// A load writes both point tables as it is taken; a start runs S_EROW then S_OUT,
// or only S_OUT on abort. A tick walks skipped points in S_TCHK, reads the row in
// S_PROW, per joint S_MUL and S_DIV (divider: one quotient bit a cycle), then S_OUT.
// Reset clears control state and the command registers; the point tables hold garbage until loaded.
// A stalled output holds the result; the next item is still taken meanwhile,
// and a result that finds the output register full waits in place.
`include "joint_trajectory_interpolator_assert.svh"

module joint_trajectory_interpolator #(
  parameter int unsigned MAX_POINTS  = jti_pkg::MAX_POINTS_DEF,
  parameter int unsigned JOINT_COUNT = jti_pkg::JOINT_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  jti_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output jti_pkg::out_t                    out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [jti_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [jti_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned AW    = $clog2(MAX_POINTS);
  localparam int unsigned CW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned RW    = JOINT_COUNT * jti_pkg::POS_W;
  localparam int unsigned JW    = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int unsigned POS_W = jti_pkg::POS_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_TCHK = 7'b0000010,
    S_EROW = 7'b0000100,
    S_PROW = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [jti_pkg::PERIOD_W-1:0] period_q;
  logic [jti_pkg::COUNT_W-1:0]  count_q;
  logic [CW-1:0]                latched_q, latched_d;
  logic [jti_pkg::TIME_W-1:0]   clock_q, clock_d;
  logic [AW-1:0]                seg_q, seg_d, wseg_q, wseg_d;
  logic                         running_q, running_d;
  logic signed [POS_W-1:0]      prev_q [JOINT_COUNT];
  logic [RW-1:0]                row_q;
  logic [jti_pkg::TIME_W-1:0]   dt_q, dt_d;
  logic [JW-1:0]                j_q, j_d;
  logic [1:0]                   status_q, status_d;
  logic [jti_pkg::IDX_W-1:0]    oseg_q, oseg_d;
  logic                         abort_q, abort_d;
  logic                         neg_q;
  logic                         outv_q;
  jti_pkg::out_t                out_q;

  logic                         in_acc, load_out;
  logic [jti_pkg::PERIOD_W-1:0] period_eff;
  logic [CW-1:0]                nsegs;
  logic [jti_pkg::TIME_W:0]     clk_sum;
  logic [jti_pkg::TIME_W-1:0]   clk_next, tsub, tleft;
  logic [31:0]                  n32;
  logic [AW-1:0]                nw;
  logic                         t_we;
  logic [AW-1:0]                waddr, t_raddr, p_raddr;
  logic [jti_pkg::TIME_W-1:0]   t_rdata;
  logic [RW-1:0]                in_row, p_rdata;
  logic signed [POS_W-1:0]      in_joint [jti_pkg::PORT_JOINTS];
  logic signed [POS_W-1:0]      out_joint [jti_pkg::PORT_JOINTS];
  logic signed [POS_W:0]        delta;
  logic signed [POS_W:0]        step;
  logic signed [POS_W-1:0]      cur_target;
  jti_pkg::div_req_t            div_req;
  jti_pkg::div_rsp_t            div_rsp;

  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign period_eff = (period_q == '0) ? jti_pkg::PERIOD_W'(1) : period_q;
  assign nsegs      = latched_q - CW'(1);
  assign clk_sum    = {1'b0, clock_q} + (jti_pkg::TIME_W + 1)'(period_eff);
  assign clk_next   = clk_sum[jti_pkg::TIME_W] ? '1 : clk_sum[jti_pkg::TIME_W-1:0];
  assign n32        = (32'(count_q) > MAX_POINTS) ? 32'(MAX_POINTS) : 32'(count_q);
  assign tsub       = t_rdata;
  assign tleft      = tsub - clock_q;
  assign nw         = wseg_q + AW'(1);

  assign in_joint[0] = in_data_i.joint_0;
  assign in_joint[1] = in_data_i.joint_1;
  assign in_joint[2] = in_data_i.joint_2;
  assign in_joint[3] = in_data_i.joint_3;
  assign in_joint[4] = in_data_i.joint_4;
  assign in_joint[5] = in_data_i.joint_5;
  assign in_joint[6] = in_data_i.joint_6;

  for (genvar g = 0; g < JOINT_COUNT; g++) begin : g_row
    assign in_row[g*POS_W +: POS_W] = in_joint[g];
  end

  for (genvar g = 0; g < jti_pkg::PORT_JOINTS; g++) begin : g_out
    if (g < JOINT_COUNT) begin : g_used
      assign out_joint[g] = abort_q ? '0 : prev_q[g];
    end else begin : g_unused
      assign out_joint[g] = '0;
    end
  end

  assign t_we  = in_acc && (in_data_i.kind == jti_pkg::KIND_LOAD)
              && (32'(in_data_i.point_index) < MAX_POINTS);
  assign waddr = AW'(in_data_i.point_index);

  jti_ram #(.WIDTH(jti_pkg::TIME_W), .DEPTH(MAX_POINTS)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (waddr),
    .wdata_i (in_data_i.point_time_us),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  jti_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (waddr),
    .wdata_i (in_row),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  assign cur_target = row_q[j_q*POS_W +: POS_W];
  assign delta      = (POS_W+1)'(cur_target) - (POS_W+1)'(prev_q[j_q]);
  assign step       = neg_q ? -$signed(div_rsp.quo) : $signed(div_rsp.quo);

  always_comb begin
    div_req.start  = (state_q == S_MUL);
    div_req.mag    = delta[POS_W] ? jti_pkg::MAG_W'(-delta) : jti_pkg::MAG_W'(delta);
    div_req.period = period_eff;
    div_req.dt     = dt_q;
  end

  jti_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign load_out = (state_q == S_OUT) && (!outv_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    latched_d = latched_q;
    clock_d   = clock_q;
    seg_d     = seg_q;
    wseg_d    = wseg_q;
    running_d = running_q;
    dt_d      = dt_q;
    j_d       = j_q;
    status_d  = status_q;
    oseg_d    = oseg_q;
    abort_d   = abort_q;
    t_raddr   = seg_q + AW'(1);
    p_raddr   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data_i.kind)
            jti_pkg::KIND_START: begin
              if (n32 < 32'd2) begin
                running_d = 1'b0;
                abort_d   = 1'b1;
                status_d  = jti_pkg::STAT_ABORTED;
                oseg_d    = jti_pkg::IDX_W'(seg_q);
                state_d   = S_OUT;
              end else begin
                latched_d = CW'(n32);
                running_d = 1'b1;
                clock_d   = '0;
                seg_d     = '0;
                abort_d   = 1'b0;
                status_d  = jti_pkg::STAT_STARTED;
                oseg_d    = '0;
                p_raddr   = '0;
                state_d   = S_EROW;
              end
            end
            jti_pkg::KIND_TICK: begin
              if (running_q) begin
                clock_d = clk_next;
                abort_d = 1'b0;
                if (CW'(seg_q) >= nsegs) begin
                  running_d = 1'b0;
                  status_d  = jti_pkg::STAT_FINISHED;
                  oseg_d    = jti_pkg::IDX_W'(seg_q);
                  p_raddr   = AW'(nsegs);
                  state_d   = S_EROW;
                end else begin
                  wseg_d  = seg_q;
                  t_raddr = seg_q + AW'(1);
                  state_d = S_TCHK;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_TCHK: begin
        if (tsub < clock_q) begin
          if (CW'(nw) >= nsegs) begin
            seg_d     = nw;
            running_d = 1'b0;
            status_d  = jti_pkg::STAT_FINISHED;
            oseg_d    = jti_pkg::IDX_W'(nw);
            p_raddr   = AW'(nsegs);
            state_d   = S_EROW;
          end else begin
            wseg_d  = nw;
            t_raddr = nw + AW'(1);
          end
        end else begin
          seg_d    = wseg_q;
          status_d = jti_pkg::STAT_MOVING;
          oseg_d   = jti_pkg::IDX_W'(wseg_q);
          dt_d     = (tleft < jti_pkg::TIME_W'(period_eff))
                   ? jti_pkg::TIME_W'(period_eff) : tleft;
          p_raddr  = wseg_q + AW'(1);
          state_d  = S_PROW;
        end
      end
      S_EROW: state_d = S_OUT;
      S_PROW: begin
        j_d     = '0;
        state_d = S_MUL;
      end
      S_MUL:  state_d = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          if (j_q == JW'(JOINT_COUNT - 1)) begin
            state_d = S_OUT;
          end else begin
            j_d     = j_q + JW'(1);
            state_d = S_MUL;
          end
        end
      end
      S_OUT: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      period_q  <= jti_pkg::PERIOD_W'(10000);
      count_q   <= '0;
      latched_q <= '0;
      clock_q   <= '0;
      seg_q     <= '0;
      wseg_q    <= '0;
      running_q <= 1'b0;
      j_q       <= '0;
      abort_q   <= 1'b0;
      outv_q    <= 1'b0;
      for (int k = 0; k < JOINT_COUNT; k++) begin
        prev_q[k] <= '0;
      end
    end else begin
      state_q   <= state_d;
      latched_q <= latched_d;
      clock_q   <= clock_d;
      seg_q     <= seg_d;
      wseg_q    <= wseg_d;
      running_q <= running_d;
      j_q       <= j_d;
      abort_q   <= abort_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          jti_pkg::REG_TICK_PERIOD: period_q <= cfg_data_i[jti_pkg::PERIOD_W-1:0];
          jti_pkg::REG_POINT_COUNT: count_q  <= cfg_data_i[jti_pkg::COUNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (state_q == S_EROW) begin
        for (int k = 0; k < JOINT_COUNT; k++) begin
          prev_q[k] <= p_rdata[k*POS_W +: POS_W];
        end
      end else if ((state_q == S_DIV) && div_rsp.done) begin
        prev_q[j_q] <= POS_W'((POS_W+1)'(prev_q[j_q]) + step);
      end
      if (load_out) begin
        outv_q <= 1'b1;
      end else if (!out_stall_i) begin
        outv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q     <= dt_d;
    status_q <= status_d;
    oseg_q   <= oseg_d;
    if (state_q == S_PROW) begin
      row_q <= p_rdata;
    end
    if (state_q == S_MUL) begin
      neg_q <= delta[POS_W];
    end
    if (load_out) begin
      out_q.cmd_joint_0 <= out_joint[0];
      out_q.cmd_joint_1 <= out_joint[1];
      out_q.cmd_joint_2 <= out_joint[2];
      out_q.cmd_joint_3 <= out_joint[3];
      out_q.cmd_joint_4 <= out_joint[4];
      out_q.cmd_joint_5 <= out_joint[5];
      out_q.cmd_joint_6 <= out_joint[6];
      out_q.status      <= status_q;
      out_q.segment     <= oseg_q;
    end
  end

  assign out_valid_o = outv_q;
  assign out_data_o  = out_q;

  `JTI_ASSERT_NOW(a_div_done_in_div, div_rsp.done, state_q == S_DIV, "divider done outside S_DIV")
  `JTI_ASSERT_NOW(a_out_from_out_state, $rose(outv_q), $past(state_q == S_OUT), "output without S_OUT")
  `JTI_ASSERT_NOW(a_seg_in_range, running_q, CW'(seg_q) < latched_q, "segment past last point")
  `JTI_ASSERT_NEXT(a_start_reads_row, in_acc && (in_data_i.kind == jti_pkg::KIND_START),
                   state_q == S_EROW || state_q == S_OUT, "start did not emit")

endmodule

@@ rtl/core/jti_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; no package needed.
module jti_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/jti_div.sv @@
// Step divider: registered multiply of delta magnitude by the period, then a
// restoring division by the time left, one quotient bit per cycle. Uses jti_pkg.
module jti_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jti_pkg::div_req_t req_i,
  output jti_pkg::div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(jti_pkg::DIV_BITS);
  localparam int unsigned HI_W  = jti_pkg::PROD_W - jti_pkg::DIV_BITS;

  logic                           busy_q, load_q, done_q;
  logic [CNT_W-1:0]               cnt_q;
  logic [jti_pkg::PROD_W-1:0]     prod_q;
  logic [jti_pkg::TIME_W-1:0]     dt_q, rem_q;
  logic [jti_pkg::DIV_BITS-1:0]   lo_q;
  logic [jti_pkg::MAG_W-1:0]      quo_q;
  logic [jti_pkg::TIME_W:0]       trial;
  logic                           fits;

  assign trial = {rem_q, lo_q[jti_pkg::DIV_BITS-1]};
  assign fits  = trial >= {1'b0, dt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      load_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        load_q <= 1'b1;
      end else if (load_q) begin
        load_q <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(jti_pkg::DIV_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q <= jti_pkg::PROD_W'(req_i.mag) * jti_pkg::PROD_W'(req_i.period);
      dt_q   <= req_i.dt;
    end else if (load_q) begin
      // The quotient fits in DIV_BITS, so the upper part is already below dt.
      rem_q <= jti_pkg::TIME_W'(prod_q[jti_pkg::PROD_W-1 -: HI_W]);
      lo_q  <= prod_q[jti_pkg::DIV_BITS-1:0];
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? jti_pkg::TIME_W'(trial - {1'b0, dt_q}) : trial[jti_pkg::TIME_W-1:0];
      lo_q  <= {lo_q[jti_pkg::DIV_BITS-2:0], 1'b0};
      quo_q <= {quo_q[jti_pkg::MAG_W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule
